// ----- rtl/core/psr_pkg.sv -----
// shared types, constants and helpers of the plane stress rotation block
package psr_pkg;

  localparam int unsigned STRESS_WIDTH = 32;
  localparam int unsigned ANGLE_BITS = 16;
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned ATAN_ENTRIES = 24;

  localparam int unsigned TURN_W = 32;
  localparam int unsigned TRIG_FRAC = 28;
  localparam int unsigned Z_W = TURN_W + 1;
  localparam int unsigned XY_W = TRIG_FRAC + 3;
  localparam int unsigned SUM_W = STRESS_WIDTH + 1;
  localparam int unsigned PROD_W = SUM_W + XY_W;
  localparam int unsigned RND_W = PROD_W + 1 - TRIG_FRAC;
  localparam int unsigned FIN_W = RND_W + 1;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(163008219);
  localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(64'h4000_0000);
  localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(64'h8000_0000);

  typedef struct packed {
    logic signed [STRESS_WIDTH-1:0] sigma_x;
    logic signed [STRESS_WIDTH-1:0] sigma_y;
    logic signed [STRESS_WIDTH-1:0] tau_xy;
    logic [ANGLE_BITS-1:0]          angle;
  } psr_in_t;

  typedef struct packed {
    logic signed [STRESS_WIDTH-1:0] rot_sigma_x;
    logic signed [STRESS_WIDTH-1:0] rot_sigma_y;
    logic signed [STRESS_WIDTH-1:0] rot_tau_xy;
  } psr_out_t;

  typedef struct packed {
    logic                    flip;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] diff;
    logic signed [SUM_W-1:0] twice;
  } psr_cell_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [Z_W-1:0] atan_turn(input int unsigned idx);
    logic signed [Z_W-1:0] val;
    case (idx)
      0:       val = Z_W'(536870912);
      1:       val = Z_W'(316933406);
      2:       val = Z_W'(167458907);
      3:       val = Z_W'(85004757);
      4:       val = Z_W'(42667331);
      5:       val = Z_W'(21354465);
      6:       val = Z_W'(10679838);
      7:       val = Z_W'(5340245);
      8:       val = Z_W'(2670163);
      9:       val = Z_W'(1335087);
      10:      val = Z_W'(667544);
      11:      val = Z_W'(333772);
      12:      val = Z_W'(166886);
      13:      val = Z_W'(83443);
      14:      val = Z_W'(41722);
      15:      val = Z_W'(20861);
      16:      val = Z_W'(10430);
      17:      val = Z_W'(5215);
      18:      val = Z_W'(2608);
      19:      val = Z_W'(1304);
      20:      val = Z_W'(652);
      21:      val = Z_W'(326);
      22:      val = Z_W'(163);
      23:      val = Z_W'(81);
      default: val = '0;
    endcase
    return val;
  endfunction

  function automatic logic signed [STRESS_WIDTH-1:0] sat_stress(
    input logic signed [RND_W-1:0] v
  );
    logic [RND_W-STRESS_WIDTH:0] upper;
    logic signed [STRESS_WIDTH-1:0] res;
    upper = v[RND_W-1:STRESS_WIDTH-1];
    if ((&upper) || !(|upper)) begin
      res = v[STRESS_WIDTH-1:0];
    end else if (v[RND_W-1]) begin
      res = {1'b1, {(STRESS_WIDTH-1){1'b0}}};
    end else begin
      res = {1'b0, {(STRESS_WIDTH-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/psr_cordic_cell.sv -----
// one rotation-mode cordic cell, forwards the stress terms alongside
module psr_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  psr_pkg::psr_cell_t cell_i,
  output logic               valid_o,
  output psr_pkg::psr_cell_t cell_o
);
  import psr_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = atan_turn(STAGE);

  logic signed [XY_W-1:0] x_in;
  logic signed [XY_W-1:0] y_in;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  psr_cell_t cell_d;
  psr_cell_t cell_q;
  logic valid_q;

  assign x_in = cell_i.x;
  assign y_in = cell_i.y;
  assign dx = y_in >>> STAGE;
  assign dy = x_in >>> STAGE;

  always_comb begin
    cell_d = cell_i;
    if (!cell_i.z[Z_W-1]) begin
      cell_d.x = x_in - dx;
      cell_d.y = y_in + dy;
      cell_d.z = cell_i.z - ATAN;
    end else begin
      cell_d.x = x_in + dx;
      cell_d.y = y_in - dy;
      cell_d.z = cell_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign valid_o = valid_q;
  assign cell_o = cell_q;

endmodule

// ----- rtl/core/psr_combine.sv -----
// sign fix, products, rounding and saturation of the rotated stresses
module psr_combine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  psr_pkg::psr_cell_t cell_i,
  output logic               done_o,
  output psr_pkg::psr_out_t  result_o
);
  import psr_pkg::*;

  localparam logic [PROD_W:0] ROUND_HALF =
    {{(PROD_W+1-TRIG_FRAC){1'b0}}, 1'b1, {(TRIG_FRAC-1){1'b0}}};

  // stage a: cos and sin with quadrant fix
  logic                    va_q;
  logic signed [XY_W-1:0]  c_a_q;
  logic signed [XY_W-1:0]  s_a_q;
  logic signed [SUM_W-1:0] sum_a_q;
  logic signed [SUM_W-1:0] diff_a_q;
  logic signed [SUM_W-1:0] twice_a_q;

  // stage b: products
  logic                     vb_q;
  logic signed [PROD_W-1:0] p_dc_q;
  logic signed [PROD_W-1:0] p_ts_q;
  logic signed [PROD_W-1:0] p_tc_q;
  logic signed [PROD_W-1:0] p_ds_q;
  logic signed [SUM_W-1:0]  sum_b_q;

  // stage c: rounded sums
  logic                    vc_q;
  logic [PROD_W:0]         r_acc;
  logic [PROD_W:0]         q_acc;
  logic signed [RND_W-1:0] r_c_q;
  logic signed [RND_W-1:0] q_c_q;
  logic signed [SUM_W-1:0] sum_c_q;

  // stage d: halving and saturation
  logic [FIN_W-1:0] fx;
  logic [FIN_W-1:0] fy;
  logic [FIN_W-1:0] ft;
  logic [FIN_W-1:0] sum_ext;
  logic [FIN_W-1:0] r_ext;
  logic [FIN_W-1:0] q_ext;
  logic             done_q;
  psr_out_t         result_d;
  psr_out_t         result_q;

  assign r_acc = {p_dc_q[PROD_W-1], p_dc_q} + {p_ts_q[PROD_W-1], p_ts_q} + ROUND_HALF;
  assign q_acc = {p_tc_q[PROD_W-1], p_tc_q} - {p_ds_q[PROD_W-1], p_ds_q} + ROUND_HALF;

  assign sum_ext = {{(FIN_W-SUM_W){sum_c_q[SUM_W-1]}}, sum_c_q};
  assign r_ext = {r_c_q[RND_W-1], r_c_q};
  assign q_ext = {q_c_q[RND_W-1], q_c_q};
  assign fx = sum_ext + r_ext + FIN_W'(1);
  assign fy = sum_ext - r_ext + FIN_W'(1);
  assign ft = q_ext + FIN_W'(1);

  always_comb begin
    result_d.rot_sigma_x = sat_stress(fx[FIN_W-1:1]);
    result_d.rot_sigma_y = sat_stress(fy[FIN_W-1:1]);
    result_d.rot_tau_xy = sat_stress(ft[FIN_W-1:1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      done_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_a_q <= cell_i.flip ? -cell_i.x : cell_i.x;
    s_a_q <= cell_i.flip ? -cell_i.y : cell_i.y;
    sum_a_q <= cell_i.sum;
    diff_a_q <= cell_i.diff;
    twice_a_q <= cell_i.twice;

    p_dc_q <= PROD_W'(diff_a_q) * PROD_W'(c_a_q);
    p_ts_q <= PROD_W'(twice_a_q) * PROD_W'(s_a_q);
    p_tc_q <= PROD_W'(twice_a_q) * PROD_W'(c_a_q);
    p_ds_q <= PROD_W'(diff_a_q) * PROD_W'(s_a_q);
    sum_b_q <= sum_a_q;

    r_c_q <= r_acc[PROD_W:TRIG_FRAC];
    q_c_q <= q_acc[PROD_W:TRIG_FRAC];
    sum_c_q <= sum_b_q;

    result_q <= result_d;
  end

  assign done_o = done_q;
  assign result_o = result_q;

endmodule

// ----- rtl/core/plane_stress_rotation.sv -----
// plane stress rotation: top level with input stage, cordic cell chain and combine stages
// result path: input register, the cordic cell chain, then combine stages a to d, each registered up to done_o
// throughput: one transaction per cycle, set by the fully pipelined cordic cell chain
// busy is never raised; the receiver cannot stall, each result shows for one cycle
// reset clears the valid bits of every stage; data registers are not reset
module plane_stress_rotation #(
  parameter int unsigned CORDIC_STAGES = psr_pkg::CORDIC_STAGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  psr_pkg::psr_in_t  cmd_i,
  output logic              done_o,
  output psr_pkg::psr_out_t result_o
);
  import psr_pkg::*;

  localparam int unsigned LATENCY = CORDIC_STAGES + 5;

  logic                   accept;
  logic [TURN_W-1:0]      turn;
  logic signed [Z_W-1:0]  z_raw;
  logic                   flip_d;
  logic signed [Z_W-1:0]  z_d;
  psr_cell_t              cell_d;
  psr_cell_t              cell_q;
  logic                   valid_q;

  logic      valid_c [CORDIC_STAGES+1];
  psr_cell_t cell_c  [CORDIC_STAGES+1];

  assign busy = 1'b0;
  assign accept = start && !busy;

  // doubled angle as a signed turn fraction, folded into the right half plane
  assign turn = {cmd_i.angle[ANGLE_BITS-2:0], 1'b0, {(TURN_W-ANGLE_BITS){1'b0}}};
  assign z_raw = {turn[TURN_W-1], turn};

  always_comb begin
    flip_d = 1'b0;
    z_d = z_raw;
    if (z_raw > QUARTER_TURN) begin
      flip_d = 1'b1;
      z_d = z_raw - HALF_TURN;
    end else if (z_raw < -QUARTER_TURN) begin
      flip_d = 1'b1;
      z_d = z_raw + HALF_TURN;
    end
  end

  always_comb begin
    cell_d.flip = flip_d;
    cell_d.x = CORDIC_GAIN;
    cell_d.y = '0;
    cell_d.z = z_d;
    cell_d.sum = {cmd_i.sigma_x[STRESS_WIDTH-1], cmd_i.sigma_x}
               + {cmd_i.sigma_y[STRESS_WIDTH-1], cmd_i.sigma_y};
    cell_d.diff = {cmd_i.sigma_x[STRESS_WIDTH-1], cmd_i.sigma_x}
                - {cmd_i.sigma_y[STRESS_WIDTH-1], cmd_i.sigma_y};
    cell_d.twice = {cmd_i.tau_xy, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cell_q <= cell_d;
    end
  end

  assign valid_c[0] = valid_q;
  assign cell_c[0] = cell_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    psr_cordic_cell #(
      .STAGE(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_c[g]),
      .cell_i (cell_c[g]),
      .valid_o(valid_c[g+1]),
      .cell_o (cell_c[g+1])
    );
  end

  psr_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_c[CORDIC_STAGES]),
    .cell_i  (cell_c[CORDIC_STAGES]),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // every accepted transaction comes out after the fixed latency
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("accepted transaction did not complete on time");

  // no result without a matching accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result without an accepted transaction");

  // a hydrostatic state with no shear keeps zero shear and its sigma_x under any rotation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(accept && cmd_i.tau_xy == '0
                     && cmd_i.sigma_x == cmd_i.sigma_y, LATENCY))
    |-> (result_o.rot_tau_xy == '0
         && result_o.rot_sigma_x == $past(cmd_i.sigma_x, LATENCY)))
    else $error("hydrostatic stress changed under rotation");

endmodule

// ----- verif/plane_stress_rotation_tb.sv -----
// testbench of plane_stress_rotation: directed corners, full-rate bursts and random traffic
`timescale 1ns / 100ps

module plane_stress_rotation_tb;

  import psr_pkg::*;

  localparam int unsigned STAGES = CORDIC_STAGES_DEF;
  localparam int unsigned DRAIN_CYCLES = STAGES + 5 + 8;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned BURST_ITEMS = 40;

  localparam longint GAIN_Q28 = 64'sd163008219;
  localparam longint QUARTER = 64'sd1073741824;
  localparam longint HALF = 64'sd2147483648;
  localparam logic signed [95:0] ROUND_Q28 = 96'sd134217728;
  localparam logic signed [95:0] STRESS_MAX = 96'sd2147483647;
  localparam logic signed [95:0] STRESS_MIN = -96'sd2147483648;

  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

  localparam longint ATAN_Q32 [24] = '{
    64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004757, 64'sd42667331,
    64'sd21354465, 64'sd10679838, 64'sd5340245, 64'sd2670163, 64'sd1335087,
    64'sd667544, 64'sd333772, 64'sd166886, 64'sd83443, 64'sd41722,
    64'sd20861, 64'sd10430, 64'sd5215, 64'sd2608, 64'sd1304,
    64'sd652, 64'sd326, 64'sd163, 64'sd81
  };

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  psr_in_t  cmd_i;
  logic     done_o;
  psr_out_t result_o;

  psr_out_t rotated_q[$];
  int unsigned mismatch_count;

  plane_stress_rotation #(
    .CORDIC_STAGES(STAGES)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic signed [31:0] clamp_stress(input logic signed [95:0] v);
    logic signed [95:0] c;
    c = v;
    if (c > STRESS_MAX) c = STRESS_MAX;
    if (c < STRESS_MIN) c = STRESS_MIN;
    return c[31:0];
  endfunction

  function automatic psr_out_t rotate_stress(input psr_in_t cmd);
    logic [ANGLE_BITS-1:0] phase;
    logic [31:0] z32;
    longint z, x, y, dx, dy;
    bit flip;
    logic signed [95:0] sx, sy, txy, sum, diff, twice, cw, sw, r, q;
    psr_out_t res;
    phase = cmd.angle << 1;
    z32 = 32'(phase) << (32 - ANGLE_BITS);
    z = longint'(signed'(z32));
    x = GAIN_Q28;
    y = 0;
    flip = 1'b0;
    if (z > QUARTER) begin
      z = z - HALF;
      flip = 1'b1;
    end else if (z < -QUARTER) begin
      z = z + HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_Q32[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_Q32[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cw = 96'(x);
    sw = 96'(y);
    sx = 96'(cmd.sigma_x);
    sy = 96'(cmd.sigma_y);
    txy = 96'(cmd.tau_xy);
    sum = sx + sy;
    diff = sx - sy;
    twice = txy + txy;
    r = (diff * cw + twice * sw + ROUND_Q28) >>> 28;
    q = (twice * cw - diff * sw + ROUND_Q28) >>> 28;
    res.rot_sigma_x = clamp_stress((sum + r + 1) >>> 1);
    res.rot_sigma_y = clamp_stress((sum - r + 1) >>> 1);
    res.rot_tau_xy = clamp_stress((q + 1) >>> 1);
    return res;
  endfunction

  always @(posedge clk_i) begin : result_check
    psr_out_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (rotated_q.size() == 0) begin
        $display("%0t: unexpected result transaction: expected none, actual %h",
                 $time, result_o);
        mismatch_count++;
      end else begin
        want = rotated_q.pop_front();
        if (result_o.rot_sigma_x !== want.rot_sigma_x) begin
          $display("%0t: rot_sigma_x mismatch: expected %0d, actual %0d",
                   $time, want.rot_sigma_x, result_o.rot_sigma_x);
          mismatch_count++;
        end
        if (result_o.rot_sigma_y !== want.rot_sigma_y) begin
          $display("%0t: rot_sigma_y mismatch: expected %0d, actual %0d",
                   $time, want.rot_sigma_y, result_o.rot_sigma_y);
          mismatch_count++;
        end
        if (result_o.rot_tau_xy !== want.rot_tau_xy) begin
          $display("%0t: rot_tau_xy mismatch: expected %0d, actual %0d",
                   $time, want.rot_tau_xy, result_o.rot_tau_xy);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_stress(input logic signed [31:0] sx, input logic signed [31:0] sy,
                             input logic signed [31:0] txy, input logic [ANGLE_BITS-1:0] ang);
    psr_in_t item;
    item.sigma_x = sx;
    item.sigma_y = sy;
    item.tau_xy = txy;
    item.angle = ang;
    start <= 1'b1;
    cmd_i <= item;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    rotated_q.push_back(rotate_stress(item));
  endtask

  task automatic idle_gap(input bit allow_long);
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 55) n = 0;
    else if (pick < 90 || !allow_long) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [31:0] pick_stress();
    int unsigned mode;
    logic signed [31:0] v;
    mode = $urandom_range(0, 9);
    case (mode)
      0: v = S_MAX;
      1: v = S_MIN;
      2: v = 0;
      3, 4: begin
        v = $urandom_range(0, 32'h0010_0000);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [ANGLE_BITS-1:0] pick_angle();
    logic [ANGLE_BITS-1:0] a;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 7))
          0: a = 16'h0000;
          1: a = 16'h2000;
          2: a = 16'h2001;
          3: a = 16'h4000;
          4: a = 16'h5FFF;
          5: a = 16'h6000;
          6: a = 16'h8000;
          default: a = 16'hFFFF;
        endcase
      end
      default: a = ANGLE_BITS'($urandom_range(0, 65535));
    endcase
    return a;
  endfunction

  task automatic test_directed_corners();
    send_stress(0, 0, 0, 16'h0000);                           idle_gap(1'b0);
    send_stress(S_MAX, S_MAX, S_MAX, 16'h0000);               idle_gap(1'b0);
    send_stress(S_MIN, S_MIN, S_MIN, 16'h0000);               idle_gap(1'b0);
    send_stress(S_MAX, S_MIN, 0, 16'h4000);                   idle_gap(1'b0);
    send_stress(S_MAX, S_MIN, S_MAX, 16'h1000);               idle_gap(1'b0);
    send_stress(S_MIN, S_MAX, S_MIN, 16'h1000);               idle_gap(1'b0);
    send_stress(S_MAX, S_MAX, S_MAX, 16'h1000);               idle_gap(1'b0);
    send_stress(S_MIN, S_MIN, S_MIN, 16'h3000);               idle_gap(1'b0);
    send_stress(0, 0, S_MAX, 16'h2000);                       idle_gap(1'b0);
    send_stress(0, 0, S_MIN, 16'h6000);                       idle_gap(1'b0);
    send_stress(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000, 16'h2001);
    idle_gap(1'b0);
    send_stress(S_MAX, 0, S_MIN, 16'h5FFF);                   idle_gap(1'b0);
    send_stress(32'sh1234_5678, -32'sh0ABC_DEF0, 32'sh00F0_0F00, 16'h8000);
    idle_gap(1'b0);
    send_stress(S_MIN, S_MAX, S_MAX, 16'hE000);               idle_gap(1'b0);
    send_stress(-1, 1, -1, 16'hFFFF);                         idle_gap(1'b0);
    send_stress(S_MAX, S_MIN, S_MIN, 16'h7FFF);               idle_gap(1'b0);
    send_stress(32'sh0001_0000, 32'sh0001_0000, 0, 16'hC000); idle_gap(1'b0);
    send_stress(S_MIN, S_MIN, S_MAX, 16'hA000);               idle_gap(1'b0);
    send_stress(S_MAX, 0, 0, 16'h2AAA);                       idle_gap(1'b0);
    send_stress(0, S_MIN, S_MAX, 16'h0001);                   idle_gap(1'b0);
  endtask

  task automatic test_full_rate_burst();
    for (int i = 0; i < BURST_ITEMS; i++) begin
      send_stress(pick_stress(), pick_stress(), pick_stress(), pick_angle());
    end
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_stress(pick_stress(), pick_stress(), pick_stress(), pick_angle());
      idle_gap(1'b1);
    end
  endtask

  initial begin
    mismatch_count = 0;
    rst_ni <= 1'b0;
    start <= 1'b0;
    cmd_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_corners();
    test_full_rate_burst();
    test_random_traffic();
    start <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("plane_stress_rotation_tb: PASS");
    end else begin
      $display("plane_stress_rotation_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("plane_stress_rotation_tb: FAIL");
    $finish;
  end

endmodule
